/* hdl/xpf_pkg.sv */
// Shared package of the 48-bit extended-precision float unit.
// Holds command and micro-operation codes, number formats and the controller/datapath structs.
// No dependencies.
package xpf_pkg;

   // Item command codes.
   localparam logic [2:0] CMD_ADD   = 3'd0;
   localparam logic [2:0] CMD_SUB   = 3'd1;
   localparam logic [2:0] CMD_MUL   = 3'd2;
   localparam logic [2:0] CMD_DIV   = 3'd3;
   localparam logic [2:0] CMD_NEG   = 3'd4;
   localparam logic [2:0] CMD_TRUNC = 3'd5;
   localparam logic [2:0] CMD_PACK  = 3'd6;
   localparam logic [2:0] CMD_CMPL  = 3'd7;

   // Datapath micro-operations.
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_LOAD     = 5'd1;
   localparam logic [4:0] OP_NEG_A    = 5'd2;
   localparam logic [4:0] OP_NEG_B    = 5'd3;
   localparam logic [4:0] OP_ALIGN    = 5'd4;
   localparam logic [4:0] OP_SUM      = 5'd5;
   localparam logic [4:0] OP_MUL_ABS  = 5'd6;
   localparam logic [4:0] OP_MULP     = 5'd7;
   localparam logic [4:0] OP_MACC     = 5'd8;
   localparam logic [4:0] OP_MUL_FIN  = 5'd9;
   localparam logic [4:0] OP_MUL_NEG  = 5'd10;
   localparam logic [4:0] OP_DIVZ     = 5'd11;
   localparam logic [4:0] OP_DIV1     = 5'd12;
   localparam logic [4:0] OP_DIV_Q1   = 5'd13;
   localparam logic [4:0] OP_DIV2     = 5'd14;
   localparam logic [4:0] OP_DIV_FIN  = 5'd15;
   localparam logic [4:0] OP_MOVA     = 5'd16;
   localparam logic [4:0] OP_TMASK    = 5'd17;
   localparam logic [4:0] OP_NORM     = 5'd18;
   localparam logic [4:0] OP_ROUND    = 5'd19;
   localparam logic [4:0] OP_FIN_PACK = 5'd20;
   localparam logic [4:0] OP_FIN_ZERO = 5'd21;
   localparam logic [4:0] OP_FIN_RAW  = 5'd22;
   localparam logic [4:0] OP_FIN_CMPL = 5'd23;

   // Partial-product selects for the shared 32x32 multiplier.
   localparam logic [2:0] SEL_HH  = 3'd0;
   localparam logic [2:0] SEL_HL  = 3'd1;
   localparam logic [2:0] SEL_LH  = 3'd2;
   localparam logic [2:0] SEL_LL  = 3'd3;
   localparam logic [2:0] SEL_QLO = 3'd4;
   localparam logic [2:0] SEL_QHI = 3'd5;

   // Working mantissa constants.
   localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MANT64   = 64'h7FFF_FFFF_FF00_0000;
   localparam logic [63:0] SMANT64  = 64'hFFFF_FFFF_FF00_0000;
   localparam logic [63:0] USMANT64 = 64'hFFFF_FFFF_FFFF_0000;
   localparam logic [63:0] HALF_POS = 64'h0000_0000_0080_0000;
   localparam logic [63:0] HALF_NEG = 64'h0000_0000_007F_FFFF;
   localparam logic [63:0] HALF64   = 64'h4000_0000_0000_0000;

   typedef struct packed {
      logic [63:0]        m;
      logic signed [17:0] e;
   } xnum_type;

   typedef struct packed {
      logic [4:0] op;
      logic [2:0] sel;
      logic       no_ovf;
   } xpf_ctrl_type;

   typedef struct packed {
      logic div_zero;
      logic div_done;
      logic norm_done;
      logic exp_neg;
      logic exp_big;
   } xpf_sts_type;

endpackage

/* hdl/xpf_sdiv.sv */
// Sequential signed divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Quotient truncates toward zero and wraps modulo 2^64. Depends on nothing.
module xpf_sdiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quot,
   output logic [31:0] rem
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] n_ff, n_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic        qneg_ff, qneg_in;
   logic        rneg_ff, rneg_in;
   logic [32:0] trial;
   logic [32:0] diff;

   // Restoring step on magnitudes; signs are applied at the outputs.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      trial   = {r_ff, n_ff[63]};
      diff    = trial - {1'b0, d_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         n_in    = dividend[63] ? 64'd0 - dividend : dividend;
         d_in    = divisor[31] ? 32'd0 - divisor : divisor;
         r_in    = 32'd0;
         qneg_in = dividend[63] ^ divisor[31];
         rneg_in = dividend[63];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            r_in = diff[31:0];
            n_in = {n_ff[62:0], 1'b1};
         end else begin
            r_in = trial[31:0];
            n_in = {n_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done = done_ff;
   assign quot = qneg_ff ? 64'd0 - n_ff : n_ff;
   assign rem  = rneg_ff ? 32'd0 - r_ff : r_ff;

endmodule

/* hdl/xpf_datapath.sv */
// Datapath of the float unit: operand, working and result registers, the aligner and
// adder, a shared 32x32 multiplier, the divider and the one-bit normalizer.
// Depends on xpf_pkg and xpf_sdiv.
module xpf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  xpf_pkg::xpf_ctrl_type ctrl,
   output xpf_pkg::xpf_sts_type  sts,
   input  logic [2:0]           req_cmd,
   input  logic [47:0]          req_operand_a,
   input  logic [47:0]          req_operand_b,
   input  logic signed [15:0]   req_pack_exponent,
   output logic [47:0]          rsp_result_value,
   output logic                 rsp_overflow_flag,
   output logic                 rsp_exp_increment
);
   import xpf_pkg::*;

   logic [63:0]        am_ff, am_in, bm_ff, bm_in, m_ff, m_in;
   logic signed [17:0] ae_ff, ae_in, be_ff, be_in, e_ff, e_in;
   logic [47:0]        raw_ff, raw_in;
   logic               skip_ff, skip_in, msign_ff, msign_in, psign_ff, psign_in;
   logic [63:0]        prod_ff, prod_in, acc_ff, acc_in, q1_ff, q1_in;
   logic [31:0]        c32_ff, c32_in, rm_ff, rm_in;
   logic [47:0]        res_ff, res_in;
   logic               ovf_ff, ovf_in, inc_ff, inc_in;

   logic signed [18:0] d;
   logic signed [18:0] nd;
   logic [63:0]        sum;
   logic [63:0]        rsum;
   logic [63:0]        tmask;
   logic [63:0]        tkept;
   logic               lost;
   logic [63:0]        cm;
   logic [31:0]        mx, my;
   xnum_type           xa, xb, xr, ua, ub;
   logic               div_start, div_done;
   logic [63:0]        div_dividend, div_quot;
   logic [31:0]        div_rem;

   function automatic xnum_type unpack48(logic [47:0] op);
      xnum_type u;
      u.m = {op[47:8], 24'd0};
      u.e = {{10{op[0]}}, op[0], op[7:1]};
      return u;
   endfunction

   // Negation; the most negative mantissa becomes one half with the exponent raised.
   function automatic xnum_type neg_x(xnum_type x);
      xnum_type r;
      r.m = 64'd0 - x.m;
      r.e = x.e;
      if (r.m == SIGN64) begin
         r.m = HALF64;
         r.e = x.e + 18'sd1;
      end
      return r;
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] x, logic [5:0] n);
      return 64'($signed(x) >>> n);
   endfunction

   function automatic logic [47:0] field48(logic [63:0] m, logic signed [17:0] e);
      return {m[63:24], e[6:0], e[17]};
   endfunction

   // Shared divider for both quotient passes.
   assign div_start    = (ctrl.op == OP_DIV1) || (ctrl.op == OP_DIV2);
   assign div_dividend = (ctrl.op == OP_DIV1) ? {am_ff[63], am_ff[63], am_ff[63:2]}
                                              : {c32_ff, 32'd0};

   xpf_sdiv u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (bm_ff[63:32]),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Multiplier operand selection.
   always_comb begin
      case (ctrl.sel)
         SEL_HH:  begin mx = am_ff[63:32]; my = bm_ff[63:32]; end
         SEL_HL:  begin mx = am_ff[63:32]; my = bm_ff[31:0];  end
         SEL_LH:  begin mx = am_ff[31:0];  my = bm_ff[63:32]; end
         SEL_LL:  begin mx = am_ff[31:0];  my = bm_ff[31:0];  end
         SEL_QLO: begin mx = bm_ff[31:0];  my = q1_ff[31:0];  end
         SEL_QHI: begin mx = bm_ff[31:0];  my = q1_ff[63:32]; end
         default: begin mx = 32'd0;        my = 32'd0;        end
      endcase
   end

   // Truncation mask: fraction bits below the binary point for exponents 0 to 39.
   always_comb begin
      tmask = 64'd0;
      for (int i = 24; i <= 62; i++) begin
         tmask[i] = (ae_ff[5:0] <= 6'(62 - i));
      end
      tkept = am_ff & ~tmask;
      lost  = |(am_ff & tmask);
   end

   // Next-state logic of all datapath registers.
   always_comb begin
      am_in = am_ff;  ae_in = ae_ff;  bm_in = bm_ff;  be_in = be_ff;
      m_in = m_ff;    e_in = e_ff;    raw_in = raw_ff;
      skip_in = skip_ff;  msign_in = msign_ff;  psign_in = psign_ff;
      prod_in = prod_ff;  acc_in = acc_ff;  q1_in = q1_ff;
      c32_in = c32_ff;    rm_in = rm_ff;
      res_in = res_ff;    ovf_in = ovf_ff;  inc_in = inc_ff;
      d    = {ae_ff[17], ae_ff} - {be_ff[17], be_ff};
      nd   = 19'sd0 - d;
      sum  = am_ff + bm_ff;
      rsum = (m_ff + (m_ff[63] ? HALF_NEG : HALF_POS)) & SMANT64;
      cm   = 64'd0 - {raw_ff, 16'd0};
      ua   = unpack48(req_operand_a);
      ub   = unpack48(req_operand_b);
      xa   = neg_x({am_ff, ae_ff});
      xb   = neg_x({bm_ff, be_ff});
      xr   = neg_x({m_ff, e_ff});
      unique case (ctrl.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            raw_in = req_operand_a;
            if (req_cmd == CMD_PACK || req_cmd == CMD_CMPL) begin
               am_in = {req_operand_a, 16'd0};
               ae_in = {{2{req_pack_exponent[15]}}, req_pack_exponent};
            end else begin
               am_in = ua.m;
               ae_in = ua.e;
            end
            bm_in = ub.m;
            be_in = ub.e;
         end
         OP_NEG_A: begin
            am_in = xa.m;
            ae_in = xa.e;
         end
         OP_NEG_B: begin
            bm_in = xb.m;
            be_in = xb.e;
         end
         // Put the larger exponent on the a side and shift the other operand right.
         OP_ALIGN: begin
            skip_in = 1'b0;
            if (am_ff == 64'd0) begin
               am_in   = bm_ff;
               ae_in   = be_ff;
               skip_in = 1'b1;
            end else if (bm_ff == 64'd0) begin
               skip_in = 1'b1;
            end else if (d > 19'sd0) begin
               if (d > 19'sd40) skip_in = 1'b1;
               else bm_in = asr64(bm_ff, d[5:0]);
            end else begin
               am_in = bm_ff;
               ae_in = be_ff;
               if (nd > 19'sd40) skip_in = 1'b1;
               else bm_in = asr64(am_ff, nd[5:0]);
            end
         end
         OP_SUM: begin
            if (skip_ff) begin
               m_in = am_ff;
               e_in = ae_ff;
            end else if (am_ff[63] == bm_ff[63] && sum[63] != am_ff[63]) begin
               m_in = {am_ff[63], sum[63:1]};
               e_in = ae_ff + 18'sd1;
            end else begin
               m_in = sum;
               e_in = ae_ff;
            end
         end
         OP_MUL_ABS: begin
            if (am_ff[63]) begin
               am_in = xa.m;
               ae_in = xa.e;
            end
            if (bm_ff[63]) begin
               bm_in = xb.m;
               be_in = xb.e;
            end
            msign_in = am_ff[63] ^ bm_ff[63];
            acc_in   = 64'd0;
            c32_in   = 32'd0;
         end
         OP_MULP: begin
            prod_in = mx * my;
         end
         // Sum partial products, low parts modulo 2^32; also the divide remainder.
         OP_MACC: begin
            case (ctrl.sel)
               SEL_HH:  acc_in = prod_ff;
               SEL_HL, SEL_LH: begin
                  acc_in = acc_ff + {32'd0, prod_ff[63:32]};
                  c32_in = c32_ff + prod_ff[31:0];
               end
               SEL_LL:  c32_in = c32_ff + prod_ff[63:32];
               SEL_QLO: c32_in = rm_ff - prod_ff[63:32];
               SEL_QHI: c32_in = c32_ff - prod_ff[31:0];
               default: c32_in = c32_ff;
            endcase
         end
         OP_MUL_FIN: begin
            m_in = (acc_ff + {47'd0, c32_ff[31:15]}) & USMANT64;
            e_in = ae_ff + be_ff + 18'sd1;
         end
         OP_MUL_NEG: begin
            if (msign_ff) begin
               m_in = xr.m;
               e_in = xr.e;
            end
         end
         OP_DIVZ: begin
            m_in = am_ff[63] ? SIGN64 : MANT64;
            e_in = 18'sd128;
         end
         OP_DIV1: begin
            e_in = ae_ff - be_ff + 18'sd1;
         end
         OP_DIV_Q1: begin
            q1_in = div_quot;
            rm_in = div_rem;
         end
         OP_DIV2: begin
         end
         OP_DIV_FIN: begin
            m_in = {q1_ff[31:0], 32'd0} + div_quot;
         end
         OP_MOVA: begin
            m_in = am_ff;
            e_in = ae_ff;
         end
         // Drop fraction bits; a negative value that lost bits gets one added.
         OP_TMASK: begin
            am_in = tkept;
            bm_in = (tkept[63] && lost) ? HALF64 : 64'd0;
            be_in = 18'sd1;
         end
         OP_NORM: begin
            if (!sts.norm_done) begin
               m_in = {m_ff[62:0], 1'b0};
               e_in = e_ff - 18'sd1;
            end
         end
         OP_ROUND: begin
            psign_in = m_ff[63];
            if (rsum[63] != m_ff[63]) begin
               m_in = {1'b0, rsum[63:1]} & SMANT64;
               e_in = e_ff + 18'sd1;
            end else begin
               m_in = rsum;
            end
         end
         OP_FIN_PACK: begin
            inc_in = 1'b0;
            if (m_ff == 64'd0) begin
               res_in = 48'd0;
               ovf_in = 1'b0;
            end else if (e_ff < -18'sd128) begin
               res_in = 48'd0;
               ovf_in = !ctrl.no_ovf;
            end else if (e_ff > 18'sd127) begin
               res_in = field48(psign_ff ? SIGN64 : MANT64, 18'sd127);
               ovf_in = !ctrl.no_ovf;
            end else begin
               res_in = field48(m_ff, e_ff);
               ovf_in = 1'b0;
            end
         end
         OP_FIN_ZERO: begin
            res_in = 48'd0;
            ovf_in = 1'b0;
            inc_in = 1'b0;
         end
         OP_FIN_RAW: begin
            res_in = raw_ff;
            ovf_in = 1'b0;
            inc_in = 1'b0;
         end
         OP_FIN_CMPL: begin
            ovf_in = 1'b0;
            if (cm == SIGN64) begin
               res_in = HALF64[63:16];
               inc_in = 1'b1;
            end else begin
               res_in = cm[63:16];
               inc_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      am_ff <= am_in;  ae_ff <= ae_in;  bm_ff <= bm_in;  be_ff <= be_in;
      m_ff <= m_in;    e_ff <= e_in;    raw_ff <= raw_in;
      skip_ff <= skip_in;  msign_ff <= msign_in;  psign_ff <= psign_in;
      prod_ff <= prod_in;  acc_ff <= acc_in;  q1_ff <= q1_in;
      c32_ff <= c32_in;    rm_ff <= rm_in;
      res_ff <= res_in;    ovf_ff <= ovf_in;  inc_ff <= inc_in;
   end

   // Status back to the controller.
   assign sts.div_zero  = (bm_ff[63:32] == 32'd0);
   assign sts.div_done  = div_done;
   assign sts.norm_done = (m_ff == 64'd0) || (m_ff[63] != m_ff[62]);
   assign sts.exp_neg   = ae_ff[17];
   assign sts.exp_big   = (ae_ff > 18'sd39);

   assign rsp_result_value  = res_ff;
   assign rsp_overflow_flag = ovf_ff;
   assign rsp_exp_increment = inc_ff;

endmodule

/* hdl/xpf_ctrl.sv */
// Controller of the float unit: sequences datapath micro-operations for each item
// and owns the input and result handshakes. Depends on xpf_pkg.
module xpf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output xpf_pkg::xpf_ctrl_type ctrl,
   input  xpf_pkg::xpf_sts_type  sts
);
   import xpf_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_DISPATCH  = 5'd1;
   localparam logic [4:0] S_NEG_B     = 5'd2;
   localparam logic [4:0] S_ALIGN     = 5'd3;
   localparam logic [4:0] S_SUM       = 5'd4;
   localparam logic [4:0] S_MUL_ABS   = 5'd5;
   localparam logic [4:0] S_MULP      = 5'd6;
   localparam logic [4:0] S_MACC      = 5'd7;
   localparam logic [4:0] S_MUL_FIN   = 5'd8;
   localparam logic [4:0] S_MUL_NEG   = 5'd9;
   localparam logic [4:0] S_DIVZ      = 5'd10;
   localparam logic [4:0] S_DIV1      = 5'd11;
   localparam logic [4:0] S_DIV1_WAIT = 5'd12;
   localparam logic [4:0] S_DIV_Q1    = 5'd13;
   localparam logic [4:0] S_DIV2      = 5'd14;
   localparam logic [4:0] S_DIV2_WAIT = 5'd15;
   localparam logic [4:0] S_DIV_FIN   = 5'd16;
   localparam logic [4:0] S_NEG_A     = 5'd17;
   localparam logic [4:0] S_MOVA      = 5'd18;
   localparam logic [4:0] S_TMASK     = 5'd19;
   localparam logic [4:0] S_NORM1     = 5'd20;
   localparam logic [4:0] S_ROUND     = 5'd21;
   localparam logic [4:0] S_NORM2     = 5'd22;
   localparam logic [4:0] S_FIN_PACK  = 5'd23;
   localparam logic [4:0] S_FIN_ZERO  = 5'd24;
   localparam logic [4:0] S_FIN_RAW   = 5'd25;
   localparam logic [4:0] S_FIN_CMPL  = 5'd26;

   logic [4:0] state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl.op      = OP_NONE;
      ctrl.sel     = cnt_ff;
      ctrl.no_ovf  = (cmd_ff == CMD_TRUNC);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.op  = OP_LOAD;
               cmd_in   = req_cmd;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (cmd_ff)
               CMD_ADD:   state_in = S_ALIGN;
               CMD_SUB:   state_in = S_NEG_B;
               CMD_MUL:   state_in = S_MUL_ABS;
               CMD_DIV:   state_in = sts.div_zero ? S_DIVZ : S_DIV1;
               CMD_NEG:   state_in = S_NEG_A;
               CMD_TRUNC: begin
                  if (sts.exp_neg) state_in = S_FIN_ZERO;
                  else if (sts.exp_big) state_in = S_FIN_RAW;
                  else state_in = S_TMASK;
               end
               CMD_PACK:  state_in = S_MOVA;
               CMD_CMPL:  state_in = S_FIN_CMPL;
               default:   state_in = S_IDLE;
            endcase
         end
         S_NEG_B: begin
            ctrl.op  = OP_NEG_B;
            state_in = S_ALIGN;
         end
         S_ALIGN: begin
            ctrl.op  = OP_ALIGN;
            state_in = S_SUM;
         end
         S_SUM: begin
            ctrl.op  = OP_SUM;
            state_in = S_NORM1;
         end
         S_MUL_ABS: begin
            ctrl.op  = OP_MUL_ABS;
            cnt_in   = SEL_HH;
            state_in = S_MULP;
         end
         S_MULP: begin
            ctrl.op  = OP_MULP;
            state_in = S_MACC;
         end
         // After the last partial product go on to the multiply or divide tail.
         S_MACC: begin
            ctrl.op = OP_MACC;
            if (cnt_ff == SEL_LL) state_in = S_MUL_FIN;
            else if (cnt_ff == SEL_QHI) state_in = S_DIV2;
            else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = S_MULP;
            end
         end
         S_MUL_FIN: begin
            ctrl.op  = OP_MUL_FIN;
            state_in = S_MUL_NEG;
         end
         S_MUL_NEG: begin
            ctrl.op  = OP_MUL_NEG;
            state_in = S_NORM1;
         end
         S_DIVZ: begin
            ctrl.op  = OP_DIVZ;
            state_in = S_NORM1;
         end
         S_DIV1: begin
            ctrl.op  = OP_DIV1;
            state_in = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (sts.div_done) state_in = S_DIV_Q1;
         end
         S_DIV_Q1: begin
            ctrl.op  = OP_DIV_Q1;
            cnt_in   = SEL_QLO;
            state_in = S_MULP;
         end
         S_DIV2: begin
            ctrl.op  = OP_DIV2;
            state_in = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            if (sts.div_done) state_in = S_DIV_FIN;
         end
         S_DIV_FIN: begin
            ctrl.op  = OP_DIV_FIN;
            state_in = S_NORM1;
         end
         S_NEG_A: begin
            ctrl.op  = OP_NEG_A;
            state_in = S_MOVA;
         end
         S_MOVA: begin
            ctrl.op  = OP_MOVA;
            state_in = S_NORM1;
         end
         S_TMASK: begin
            ctrl.op  = OP_TMASK;
            state_in = S_ALIGN;
         end
         S_NORM1: begin
            ctrl.op = OP_NORM;
            if (sts.norm_done) state_in = S_ROUND;
         end
         S_ROUND: begin
            ctrl.op  = OP_ROUND;
            state_in = S_NORM2;
         end
         S_NORM2: begin
            ctrl.op = OP_NORM;
            if (sts.norm_done) state_in = S_FIN_PACK;
         end
         // Results are written only once the output register is free.
         S_FIN_PACK, S_FIN_ZERO, S_FIN_RAW, S_FIN_CMPL: begin
            if (out_free) begin
               unique case (state_ff)
                  S_FIN_PACK: ctrl.op = OP_FIN_PACK;
                  S_FIN_ZERO: ctrl.op = OP_FIN_ZERO;
                  S_FIN_RAW:  ctrl.op = OP_FIN_RAW;
                  default:    ctrl.op = OP_FIN_CMPL;
               endcase
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      cnt_ff <= cnt_in;
   end

`ifndef NO_ASSERTIONS
   // A result is never written over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_FIN_PACK || ctrl.op == OP_FIN_ZERO || ctrl.op == OP_FIN_RAW ||
       ctrl.op == OP_FIN_CMPL) |-> out_free)
      else $error("result written while output still pending");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == S_DIV1_WAIT || state_ff == S_DIV2_WAIT))
      else $error("divider finished outside a wait state");

   // An accepted item always leaves idle for dispatch.
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted item not dispatched");

   // Reset leaves the block idle with no result.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE && !rsp_valid_ff))
      else $error("not idle after reset");
`endif

endmodule

/* hdl/xp_float_alu_48bit_top.sv */
// Rate: one item at a time. Pack, add, subtract, negate, multiply and divide end by
// normalizing with one-bit shifts, rounding and normalizing again; multiply uses one
// shared 32x32 multiplier for its partial products, and divide makes two passes of the
// 64-step restoring divider. Complement, and truncate with an exponent below zero or
// above 39, go straight to the result; any other truncate masks, aligns, sums and
// normalizes. A finished result waits in the output register while the next item is
// taken. The unit has no configuration and no state between items.
// Top level; depends on xpf_pkg, xpf_ctrl, xpf_datapath and xpf_sdiv.
module xp_float_alu_48bit_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_cmd,
   input  logic [47:0]         req_operand_a,
   input  logic [47:0]         req_operand_b,
   input  logic signed [15:0]  req_pack_exponent,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [47:0]         rsp_result_value,
   output logic                rsp_overflow_flag,
   output logic                rsp_exp_increment
);
   import xpf_pkg::*;

   xpf_ctrl_type ctrl;
   xpf_sts_type  sts;

   // Sequencer.
   xpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl),
      .sts       (sts)
   );

   // Arithmetic and result registers.
   xpf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .sts               (sts),
      .req_cmd           (req_cmd),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_pack_exponent (req_pack_exponent),
      .rsp_result_value  (rsp_result_value),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_exp_increment (rsp_exp_increment)
   );

endmodule

/* dv/xpf_checker.sv */
// Checker for the 48-bit extended-precision float unit: predicts each result and compares.
// Watches the request and response channels of xp_float_alu_48bit_top.
// Depends on xpf_pkg for the command codes and the mantissa constants.
module xpf_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [2:0]          req_cmd,
   input  logic [47:0]         req_operand_a,
   input  logic [47:0]         req_operand_b,
   input  logic signed [15:0]  req_pack_exponent,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [47:0]         rsp_result_value,
   input  logic                rsp_overflow_flag,
   input  logic                rsp_exp_increment,
   output int                  fail_count,
   output int                  pending_count,
   output int                  checked_count
);
   import xpf_pkg::*;

   typedef struct {
      logic [63:0] m;
      int          e;
   } wnum_type;

   typedef struct {
      logic [47:0] value;
      logic        ovf;
      logic        inc;
   } fp_result_type;

   fp_result_type awaited_results[$];

   initial begin
      fail_count    = 0;
      checked_count = 0;
   end

   assign pending_count = awaited_results.size();

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Arithmetic shift right with the saturation of an oversized count.
   function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
      if (n >= 64) return x[63] ? '1 : '0;
      return $signed(x) >>> n;
   endfunction

   function automatic longint quo64(input longint a, input longint b);
      if (b == -1) return -a;
      return a / b;
   endfunction

   function automatic longint rem64(input longint a, input longint b);
      if (b == -1) return 0;
      return a % b;
   endfunction

   // Place a working mantissa and exponent into the packed 48-bit layout.
   function automatic logic [47:0] to_packed(input logic [63:0] m, input int e);
      logic [47:0] v;
      v = m[63:16];
      v[7:1] = v[7:1] | e[6:0];
      v[0] = v[0] | (e < 0);
      return v;
   endfunction

   function automatic wnum_type unpack_op(input logic [47:0] op);
      wnum_type u;
      u.m = {op[47:8], 24'h0};
      u.e = op[0] ? int'(op[7:1]) - 128 : int'(op[7:1]);
      return u;
   endfunction

   function automatic wnum_type norm_w(input wnum_type u);
      if (u.m != 0) begin
         while (u.m[63] == u.m[62]) begin
            u.e--;
            u.m = u.m << 1;
         end
      end else begin
         u.e = 0;
      end
      return u;
   endfunction

   function automatic wnum_type neg_w(input wnum_type u);
      u.m = -u.m;
      if (u.m == SIGN64) begin
         u.m = u.m >> 1;
         u.e++;
      end
      return u;
   endfunction

   // Normalize, round by half an LSB, saturate on overflow and flush to zero on underflow.
   function automatic logic [47:0] round_pack(input wnum_type u, output logic ovf);
      logic s;
      u = norm_w(u);
      s = u.m[63];
      u.m = (u.m + (s ? HALF_NEG : HALF_POS)) & SMANT64;
      if (s != u.m[63]) begin
         u.m = (u.m >> 1) & SMANT64;
         u.e++;
      end else begin
         u = norm_w(u);
      end
      u.m &= SMANT64;
      ovf = 0;
      if (u.m == 0) return '0;
      if (u.e < -128) begin
         ovf = 1;
         return '0;
      end
      if (u.e > 127) begin
         ovf = 1;
         return to_packed(s ? SIGN64 : MANT64, 127);
      end
      return to_packed(u.m, u.e);
   endfunction

   function automatic wnum_type sum_w(input wnum_type a, input wnum_type b);
      wnum_type r;
      int d;
      if (a.m == 0) return b;
      if (b.m == 0) return a;
      d = a.e - b.e;
      if (d > 0) begin
         r = a;
         if (d <= 40) b.m = sra64(b.m, d);
      end else begin
         r = b;
         d = -d;
         if (d <= 40) a.m = sra64(a.m, d);
      end
      if (d <= 40) begin
         r.m = b.m + a.m;
         if (b.m[63] == a.m[63] && b.m[63] != r.m[63]) begin
            r.m = (b.m & SIGN64) | (r.m >> 1);
            r.e++;
         end
      end
      return r;
   endfunction

   function automatic wnum_type prod_w(input wnum_type a, input wnum_type b);
      wnum_type r;
      logic s;
      logic [63:0] ah, al, bh, bl, hi, p1, p2, p3;
      logic [31:0] low_sum;
      r.m = 0;
      r.e = 0;
      s = 0;
      if (a.m == 0 || b.m == 0) return r;
      if (a.m[63]) begin
         a = neg_w(a);
         s = !s;
      end
      if (b.m[63]) begin
         b = neg_w(b);
         s = !s;
      end
      r.e = a.e + b.e + 1;
      ah = a.m >> 32;
      al = a.m & 64'hFFFF_FFFF;
      bh = b.m >> 32;
      bl = b.m & 64'hFFFF_FFFF;
      hi = ah * bh;
      p1 = ah * bl;
      p2 = al * bh;
      p3 = al * bl;
      low_sum = p1[31:0] + p2[31:0] + p3[63:32];
      r.m = (hi + (p1 >> 32) + (p2 >> 32) + 64'(low_sum >> 15)) & USMANT64;
      if (s) r = neg_w(r);
      return r;
   endfunction

   // Quotient from a 32-bit divisor estimate and one correction step.
   function automatic wnum_type quot_w(input wnum_type a, input wnum_type b);
      wnum_type r;
      longint d, bh, q1, rm, q2;
      logic [63:0] bl, uq1, corr, t;
      bh = longint'(sra64(b.m, 32));
      if (b.m == 0 || bh == 0) begin
         r.m = a.m[63] ? SIGN64 : MANT64;
         r.e = 128;
         return r;
      end
      r.m = 0;
      r.e = 0;
      if (a.m == 0) return r;
      r.e = a.e - b.e + 1;
      bl = b.m & 64'hFFFF_FFFF;
      d = longint'(sra64(a.m, 2));
      q1 = quo64(d, bh);
      rm = rem64(d, bh);
      uq1 = q1;
      corr = bl * uq1;
      t = 64'(rm) - sra64(corr, 32);
      q2 = quo64(longint'(t << 32), bh);
      r.m = (uq1 << 32) + 64'(q2);
      return r;
   endfunction

   function automatic logic [47:0] trunc_op(input logic [47:0] op);
      wnum_type u, one;
      logic [63:0] mask;
      logic lost, unused_ovf;
      u = unpack_op(op);
      if (u.e < 0) return '0;
      if (u.e > 39) return op;
      mask = (MANT64 >> u.e) & MANT64;
      lost = (u.m & mask) != 0;
      u.m &= ~mask;
      if (u.m[63] && lost) begin
         one.m = 64'h4000_0000_0000_0000;
         one.e = 1;
         u = sum_w(u, one);
      end
      return round_pack(u, unused_ovf);
   endfunction

   function automatic fp_result_type predict_result(input logic [2:0] cmd,
                                                    input logic [47:0] a,
                                                    input logic [47:0] b,
                                                    input logic signed [15:0] pe);
      fp_result_type r;
      wnum_type x;
      r.ovf = 0;
      r.inc = 0;
      case (cmd)
         CMD_ADD: r.value = round_pack(sum_w(unpack_op(a), unpack_op(b)), r.ovf);
         CMD_SUB: r.value = round_pack(sum_w(unpack_op(a), neg_w(unpack_op(b))), r.ovf);
         CMD_MUL: r.value = round_pack(prod_w(unpack_op(a), unpack_op(b)), r.ovf);
         CMD_DIV: r.value = round_pack(quot_w(unpack_op(a), unpack_op(b)), r.ovf);
         CMD_NEG: r.value = round_pack(neg_w(unpack_op(a)), r.ovf);
         CMD_TRUNC: r.value = trunc_op(a);
         CMD_PACK: begin
            x.m = {a, 16'h0};
            x.e = pe;
            r.value = round_pack(x, r.ovf);
         end
         default: begin
            x.m = {a, 16'h0};
            x.e = 0;
            x = neg_w(x);
            r.inc = x.e[0];
            r.value = to_packed(x.m, 0);
         end
      endcase
      return r;
   endfunction

   // Queue a prediction per accepted request; check each accepted response.
   always @(posedge clock) begin
      fp_result_type exp_r;
      if (!reset) begin
         if (req_valid && req_ready)
            awaited_results.push_back(predict_result(req_cmd, req_operand_a, req_operand_b,
                                                     req_pack_exponent));
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report("result arrived with no item outstanding");
            end else begin
               exp_r = awaited_results.pop_front();
               checked_count++;
               if (rsp_result_value !== exp_r.value)
                  report($sformatf("value %h, expected %h", rsp_result_value, exp_r.value));
               if (rsp_overflow_flag !== exp_r.ovf)
                  report($sformatf("overflow %b, expected %b", rsp_overflow_flag, exp_r.ovf));
               if (rsp_exp_increment !== exp_r.inc)
                  report($sformatf("exp increment %b, expected %b", rsp_exp_increment,
                                   exp_r.inc));
            end
         end
      end
   end

endmodule

/* dv/tb.sv */
// Testbench top for the 48-bit extended-precision float unit: stimulus and verdict.
// Drives xp_float_alu_48bit_top through its request channel and paces its response channel.
// Depends on xpf_pkg and on xpf_checker, which predicts and compares.
module tb;
   import xpf_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [2:0]         req_cmd = CMD_ADD;
   logic [47:0]        req_operand_a = '0;
   logic [47:0]        req_operand_b = '0;
   logic signed [15:0] req_pack_exponent = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [47:0]        rsp_result_value;
   logic               rsp_overflow_flag;
   logic               rsp_exp_increment;
   int                 fail_count, pending_count, checked_count;
   int                 sent_count = 0;
   bit                 hold_rsp = 0;

   xp_float_alu_48bit_top dut (.*);

   xpf_checker chk (.*);

   always #2 clock = ~clock;

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // Build a packed number from a 40-bit mantissa and an 8-bit exponent.
   function automatic logic [47:0] mk_num(input logic [39:0] mant, input logic [7:0] ex);
      return {mant, ex[6:0], ex[7]};
   endfunction

   // Random operand: mostly normalized with a modest exponent, plus raw and edge patterns.
   function automatic logic [47:0] rand_num();
      logic [39:0] mant;
      logic [7:0] ex;
      mant = {$urandom, 8'($urandom)};
      mant[38] = ~mant[39];
      ex = 8'($signed($urandom_range(0, 40)) - 20);
      case ($urandom_range(0, 9))
         0: return {$urandom, 16'($urandom)};
         1: return '0;
         2: return mk_num(mant, $urandom_range(0, 1) ? 8'sd127 - 8'($urandom_range(0, 3))
                                                   : 8'h80 + 8'($urandom_range(0, 3)));
         3: return mk_num(mant, 8'($urandom));
         default: return mk_num(mant, ex);
      endcase
   endfunction

   // Receiver pacing, with a long hold-off when the stimulus asks for it.
   initial begin
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Offer one item and hold it until accepted, then, when gaps are allowed, sometimes idle for a random gap.
   task automatic send_item(input logic [2:0] cmd, input logic [47:0] a, input logic [47:0] b,
                            input logic signed [15:0] pe, input bit allow_gap);
      req_valid <= 1;
      req_cmd <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      req_pack_exponent <= pe;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent_count++;
      if (allow_gap && $urandom_range(0, 2) == 0) begin
         req_valid <= 0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_random(input bit allow_gap);
      logic [2:0] cmd;
      logic [47:0] a, b;
      logic signed [15:0] pe;
      cmd = 3'($urandom);
      a = rand_num();
      b = rand_num();
      pe = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 300)) - 150);
      if (cmd == CMD_PACK || cmd == CMD_CMPL) begin
         a = {$urandom, 16'($urandom)};
         if ($urandom_range(0, 7) == 0) a = 48'h8000_0000_0000;
         if ($urandom_range(0, 7) == 0) a = a >> $urandom_range(1, 47);
      end
      if (cmd == CMD_TRUNC)
         a = mk_num(a[47:8], 8'($signed($urandom_range(0, 50)) - 4));
      if (cmd == CMD_DIV && $urandom_range(0, 7) == 0) b[47:16] = '0;
      send_item(cmd, a, b, pe, allow_gap);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed items: every command, zeros, extremes and the special cases.
      send_item(CMD_ADD, mk_num(40'h40_0000_0000, 8'd1), mk_num(40'h40_0000_0000, 8'd1), 0, 1);
      send_item(CMD_ADD, mk_num(40'h7F_FFFF_FFFF, 8'd127), mk_num(40'h7F_FFFF_FFFF, 8'd127),
                0, 1);
      send_item(CMD_ADD, '0, '0, 0, 1);
      send_item(CMD_SUB, mk_num(40'h40_0000_0000, 8'd3), mk_num(40'h40_0000_0001, 8'd3), 0, 1);
      send_item(CMD_SUB, mk_num(40'h80_0000_0000, 8'd127), mk_num(40'h7F_FFFF_FFFF, 8'd127),
                0, 1);
      send_item(CMD_MUL, mk_num(40'h40_0000_0000, 8'h80), mk_num(40'h40_0000_0000, 8'h80), 0, 1);
      send_item(CMD_MUL, mk_num(40'h80_0000_0000, 8'd127), mk_num(40'h80_0000_0000, 8'd127),
                0, 1);
      send_item(CMD_MUL, '1, '1, 0, 1);
      send_item(CMD_DIV, mk_num(40'h60_0000_0000, 8'd2), '0, 0, 1);
      send_item(CMD_DIV, mk_num(40'hA0_0000_0000, 8'd2), '0, 0, 1);
      send_item(CMD_DIV, '0, '0, 0, 1);
      send_item(CMD_DIV, mk_num(40'h60_0000_0000, 8'd2), 48'h0000_FFFF_FFFF, 0, 1);
      send_item(CMD_DIV, mk_num(40'h80_0000_0000, 8'd5), mk_num(40'hC0_0000_0000, 8'd1), 0, 1);
      send_item(CMD_NEG, mk_num(40'h80_0000_0000, 8'd127), '0, 0, 1);
      send_item(CMD_NEG, '0, '0, 0, 1);
      send_item(CMD_TRUNC, mk_num(40'h55_5555_5555, 8'hFF), '0, 0, 1);
      send_item(CMD_TRUNC, mk_num(40'h55_5555_5555, 8'd40), '0, 0, 1);
      send_item(CMD_TRUNC, mk_num(40'hA5_5555_5555, 8'd5), '0, 0, 1);
      send_item(CMD_TRUNC, mk_num(40'h40_0000_0000, 8'd0), '0, 0, 1);
      send_item(CMD_PACK, 48'h0000_0000_0001, '0, 16'sh7FFF, 1);
      send_item(CMD_PACK, 48'h4000_0000_0000, '0, -16'sh8000, 1);
      send_item(CMD_PACK, '1, '0, 16'sd5, 1);
      send_item(CMD_CMPL, 48'h8000_0000_0000, '0, 0, 1);
      send_item(CMD_CMPL, 48'h0000_0000_0001, '0, 0, 1);
      send_item(CMD_CMPL, '0, '0, 0, 1);

      // Hold the receiver off while items keep coming, so the unit backs up.
      hold_rsp = 1;
      repeat (20) send_random(0);
      req_valid <= 0;
      wait_drained();

      // Random items, with one pause until every result has come back.
      for (int i = 0; i < 400; i++) begin
         send_random(1);
         if (i == 200) begin
            req_valid <= 0;
            wait_drained();
         end
      end
      req_valid <= 0;

      // Drain, then allow for the slowest operation to finish.
      wait_drained();
      repeat (400) @(posedge clock);
      $display("Sent %0d items across all eight commands; %0d results checked.",
               sent_count, checked_count);
      $display("Included overflow, underflow, divide by zero and long receiver stalls.");
      if (fail_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #8000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
